### rtl/core/tafa_pkg.sv
// Shared types, constants and helpers for the tilt angle core.
`timescale 1ns / 1ps
package tafa_pkg;

   typedef struct packed {
      logic signed [15:0] raw_x;
      logic signed [15:0] raw_y;
      logic signed [15:0] raw_z;
   } req_type;

   typedef struct packed {
      logic signed [23:0] filt_x;
      logic signed [23:0] filt_y;
      logic signed [23:0] filt_z;
      logic [15:0]        roll_deg;
      logic [15:0]        pitch_deg;
      logic [15:0]        roll_error;
      logic [15:0]        pitch_error;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] b0;
      logic signed [15:0] b1;
      logic signed [15:0] b2;
      logic signed [15:0] a1;
      logic signed [15:0] a2;
   } coef_type;

   typedef struct packed {
      logic start;
      logic done;
   } lane_ctl_type;

   localparam logic [2:0] REG_COEF_B0       = 3'd0;
   localparam logic [2:0] REG_COEF_B1       = 3'd1;
   localparam logic [2:0] REG_COEF_B2       = 3'd2;
   localparam logic [2:0] REG_COEF_A1       = 3'd3;
   localparam logic [2:0] REG_COEF_A2       = 3'd4;
   localparam logic [2:0] REG_TARGET_ROLL   = 3'd5;
   localparam logic [2:0] REG_TARGET_PITCH  = 3'd6;
   localparam logic [2:0] REG_DEADBAND      = 3'd7;

   localparam int ACC_W        = 52;
   localparam int ATAN_ENTRIES = 24;
   localparam int ATAN_IDX_W   = 5;

   localparam logic signed [23:0] SAT_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] SAT_MIN = -24'sh800000;

   // calibration matrix, Q.22
   localparam logic signed [23:0] CAL_MAT [3][3] = '{
      '{ 24'sd4359062,  24'sd29992,   24'sd34599   },
      '{ -24'sd307981,  24'sd4122327, 24'sd101047  },
      '{ -24'sd440413,  -24'sd60104,  24'sd4240463 }
   };

   // calibration offsets, Q.20
   localparam logic signed [23:0] CAL_OFF [3] = '{ 24'sd2323, 24'sd18591, -24'sd5486 };

   // atan(2^-i), 2^-16 degree
   localparam logic [21:0] ATAN_TAB [ATAN_ENTRIES] = '{
      22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
      22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
      22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
      22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
   };

   function automatic logic signed [23:0] sat24(input logic signed [ACC_W-1:0] v);
      logic signed [23:0] r;
      if (v > ACC_W'(SAT_MAX)) begin
         r = SAT_MAX;
      end else if (v < ACC_W'(SAT_MIN)) begin
         r = SAT_MIN;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

endpackage

### rtl/core/tafa_axis_lane.sv
// One axis lane: calibration row and biquad filter on a shared multiplier.
`timescale 1ns / 1ps
module tafa_axis_lane #(
   parameter int AXIS        = 0,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  tafa_pkg::lane_ctl_type     ctl_in,
   output logic                       done,
   input  tafa_pkg::req_type          req,
   input  tafa_pkg::coef_type         coef,
   output logic signed [23:0]         filt
);

   localparam int AW = tafa_pkg::ACC_W;

   logic [24:0]                   raw_u [3];
   logic signed [SAMPLE_BITS-1:0] smp_n [3];
   logic signed [24:0]            smp   [3];

   logic [3:0]           cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic signed [23:0]   norm_ff, norm_in;
   logic signed [23:0]   ih0_ff, ih0_in, ih1_ff, ih1_in;
   logic signed [23:0]   oh0_ff, oh0_in, oh1_ff, oh1_in;
   logic signed [23:0]   filt_ff, filt_in;

   logic signed [24:0]   ma, mb;
   logic signed [49:0]   prod;
   logic signed [AW-1:0] acc_sum;
   logic signed [AW-1:0] cal_rnd;
   logic signed [AW-1:0] flt_rnd;

   assign raw_u[0] = {9'd0, req.raw_x};
   assign raw_u[1] = {9'd0, req.raw_y};
   assign raw_u[2] = {9'd0, req.raw_z};

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         smp_n[k] = raw_u[k][SAMPLE_BITS-1:0];
         smp[k]   = 25'(smp_n[k]);
      end
   end

   always_comb begin
      ma = '0;
      mb = '0;
      case (cnt_ff)
         4'd0, 4'd1, 4'd2: begin
            ma = 25'(tafa_pkg::CAL_MAT[AXIS][cnt_ff[1:0]]);
            mb = smp[cnt_ff[1:0]];
         end
         4'd4: begin
            ma = 25'(coef.b0);
            mb = 25'(norm_ff);
         end
         4'd5: begin
            ma = 25'(coef.b1);
            mb = 25'(ih0_ff);
         end
         4'd6: begin
            ma = 25'(coef.b2);
            mb = 25'(ih1_ff);
         end
         4'd7: begin
            ma = 25'(coef.a1);
            mb = 25'(oh0_ff);
         end
         4'd8: begin
            ma = 25'(coef.a2);
            mb = 25'(oh1_ff);
         end
         default: begin
            ma = '0;
            mb = '0;
         end
      endcase
   end

   assign prod    = ma * mb;
   assign acc_sum = acc_ff + AW'(prod);
   assign cal_rnd = ((acc_ff + AW'(2048)) >>> 12) + AW'(tafa_pkg::CAL_OFF[AXIS]);
   assign flt_rnd = (acc_ff + AW'(8192)) >>> 14;

   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      acc_in  = acc_ff;
      norm_in = norm_ff;
      ih0_in  = ih0_ff;
      ih1_in  = ih1_ff;
      oh0_in  = oh0_ff;
      oh1_in  = oh1_ff;
      filt_in = filt_ff;
      if (ctl_in.start) begin
         cnt_in  = '0;
         busy_in = 1'b1;
         acc_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd3) begin
            norm_in = tafa_pkg::sat24(cal_rnd);
            acc_in  = '0;
         end else if (cnt_ff == 4'd9) begin
            filt_in = tafa_pkg::sat24(flt_rnd);
            ih1_in  = ih0_ff;
            ih0_in  = norm_ff;
            oh1_in  = oh0_ff;
            oh0_in  = tafa_pkg::sat24(flt_rnd);
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            acc_in = acc_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         ih0_ff  <= '0;
         ih1_ff  <= '0;
         oh0_ff  <= '0;
         oh1_ff  <= '0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
         ih0_ff  <= ih0_in;
         ih1_ff  <= ih1_in;
         oh0_ff  <= oh0_in;
         oh1_ff  <= oh1_in;
      end
      acc_ff  <= acc_in;
      norm_ff <= norm_in;
      filt_ff <= filt_in;
   end

   assign done = done_ff;
   assign filt = filt_ff;

endmodule

### rtl/core/tafa_cordic.sv
// Iterative vectoring CORDIC giving atan2 in degrees, wrapped to 0 up to but not including 360.
`timescale 1ns / 1ps
module tafa_cordic #(
   parameter int ANGLE_FRAC_BITS = 7,
   parameter int CORDIC_ITERS    = 16,
   parameter int ANG_W           = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tafa_pkg::lane_ctl_type ctl_in,
   output logic                   done,
   input  logic signed [24:0]     num,
   input  logic signed [23:0]     den,
   output logic [ANG_W-1:0]       angle
);

   localparam int IW    = tafa_pkg::ATAN_IDX_W;
   localparam int NI    = (CORDIC_ITERS < tafa_pkg::ATAN_ENTRIES) ?
                          CORDIC_ITERS : tafa_pkg::ATAN_ENTRIES;
   localparam int SH    = 16 - ANGLE_FRAC_BITS;
   localparam int XW    = 36;
   localparam int PW    = 26;
   localparam logic [IW-1:0]       LAST = IW'(NI);
   localparam logic signed [PW-1:0] FULL = PW'(360 << ANGLE_FRAC_BITS);
   localparam logic signed [PW-1:0] QTR  = PW'(90 << 16);
   localparam logic signed [PW-1:0] HALF = PW'(1 << (SH - 1));

   logic signed [XW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [PW-1:0] p_ff, p_in;
   logic [IW-1:0]        it_ff, it_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 zero_ff, zero_in;
   logic [ANG_W-1:0]     ang_ff, ang_in;

   logic signed [XW-1:0] x0, y0, dx, dy;
   logic signed [PW-1:0] step;
   logic signed [PW-1:0] r0, r1, r2, r3;

   assign x0   = XW'(den) <<< 8;
   assign y0   = XW'(num) <<< 8;
   assign dx   = y_ff >>> it_ff;
   assign dy   = x_ff >>> it_ff;
   assign step = PW'(tafa_pkg::ATAN_TAB[it_ff]);

   always_comb begin
      r0 = (p_ff + HALF) >>> SH;
      r1 = (r0 < 0) ? r0 + FULL : r0;
      r2 = (r1 >= FULL) ? r1 - FULL : r1;
      r3 = (r2 < 0) ? '0 : r2;
   end

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      p_in    = p_ff;
      it_in   = it_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      zero_in = zero_ff;
      ang_in  = ang_ff;
      if (ctl_in.start) begin
         busy_in = 1'b1;
         it_in   = '0;
         zero_in = (num == 25'sd0) && (den == 24'sd0);
         if (x0 < 0) begin
            if (y0 >= 0) begin
               x_in = y0;
               y_in = -x0;
               p_in = QTR;
            end else begin
               x_in = -y0;
               y_in = x0;
               p_in = -QTR;
            end
         end else begin
            x_in = x0;
            y_in = y0;
            p_in = '0;
         end
      end else if (busy_ff) begin
         if (it_ff < LAST) begin
            it_in = it_ff + 1'b1;
            if (y_ff >= 0) begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               p_in = p_ff + step;
            end else begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               p_in = p_ff - step;
            end
         end else begin
            ang_in  = zero_ff ? '0 : r3[ANG_W-1:0];
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         it_ff   <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         it_ff   <= it_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      p_ff    <= p_in;
      zero_ff <= zero_in;
      ang_ff  <= ang_in;
   end

   assign done  = done_ff;
   assign angle = ang_ff;

endmodule

### rtl/core/tafa_merge.sv
// Merge of lane and angle results: target errors with deadband, result packing.
`timescale 1ns / 1ps
module tafa_merge #(
   parameter int ANG_W = 16
) (
   input  logic signed [23:0] filt_x,
   input  logic signed [23:0] filt_y,
   input  logic signed [23:0] filt_z,
   input  logic [ANG_W-1:0]   roll,
   input  logic [ANG_W-1:0]   pitch,
   input  logic [15:0]        target_roll,
   input  logic [15:0]        target_pitch,
   input  logic [15:0]        deadband,
   output tafa_pkg::rsp_type  rsp
);

   localparam int CW = (ANG_W > 16) ? ANG_W : 16;

   logic [CW-1:0] roll_w, pitch_w, troll_w, tpitch_w, db_w;
   logic [CW-1:0] roll_d, pitch_d, roll_e, pitch_e;

   always_comb begin
      roll_w   = CW'(roll);
      pitch_w  = CW'(pitch);
      troll_w  = CW'(target_roll);
      tpitch_w = CW'(target_pitch);
      db_w     = CW'(deadband);
      roll_d   = (roll_w >= troll_w) ? roll_w - troll_w : troll_w - roll_w;
      pitch_d  = (pitch_w >= tpitch_w) ? pitch_w - tpitch_w : tpitch_w - pitch_w;
      roll_e   = (roll_d < db_w) ? '0 : roll_d;
      pitch_e  = (pitch_d < db_w) ? '0 : pitch_d;
      rsp.filt_x      = filt_x;
      rsp.filt_y      = filt_y;
      rsp.filt_z      = filt_z;
      rsp.roll_deg    = roll_w[15:0];
      rsp.pitch_deg   = pitch_w[15:0];
      rsp.roll_error  = roll_e[15:0];
      rsp.pitch_error = pitch_e[15:0];
   end

endmodule

### rtl/core/tilt_angle_from_accel_core.sv
// Top level of the accelerometer tilt angle core.
`timescale 1ns / 1ps
// Usage:
//  req channel: one raw X/Y/Z sample per request (req_valid/req_stall/req_data).
//  rsp channel: filtered axes, roll, pitch and their target errors
//    (rsp_valid/rsp_stall/rsp_data), exactly one response per request.
//  csr port: csr_we writes csr_wdata to register csr_index at the clock edge.
//    Write only while no request is in flight.
//  Three axis lanes run side by side, each on its own multiplier, then the
//    roll and pitch CORDIC units run one iteration per cycle side by side, and
//    the merged result is then placed in the output register.
//  A new request is taken only after the previous response has been placed in
//    the output register; req_stall stays high while a request is in flight.
//  A finished response sits in the output register; the next request is taken
//    meanwhile and waits at the merge stage if rsp_stall is still high.
//  Reset (synchronous, active high) clears filter history, loads register
//    defaults and drops rsp_valid.
module tilt_angle_from_accel_core #(
   parameter int SAMPLE_BITS     = 16,
   parameter int ANGLE_FRAC_BITS = 7,
   parameter int CORDIC_ITERS    = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tafa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tafa_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_wdata
);

   localparam int ANG_W = $clog2(360 << ANGLE_FRAC_BITS);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_FILT  = 4'b0010,
      ST_ANGLE = 4'b0100,
      ST_DRAIN = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   tafa_pkg::coef_type coef_ff, coef_in;
   logic [15:0] troll_ff, troll_in, tpitch_ff, tpitch_in, db_ff, db_in;

   tafa_pkg::req_type req_ff, req_in;
   tafa_pkg::rsp_type rsp_ff, rsp_in, merged;
   logic              rsp_valid_ff, rsp_valid_in;

   tafa_pkg::lane_ctl_type lane_ctl, cord_ctl;
   logic [2:0]         lane_done;
   logic signed [23:0] filt [3];
   logic               roll_done, pitch_done;
   logic [ANG_W-1:0]   roll, pitch;
   logic               req_take, out_free;

   assign req_take = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   assign lane_ctl.start = req_take;
   assign lane_ctl.done  = 1'b0;
   assign cord_ctl.start = (state_ff == ST_FILT) && lane_done[0];
   assign cord_ctl.done  = 1'b0;

   assign req_in = req_take ? req_data : req_ff;

   for (genvar g = 0; g < 3; g++) begin : g_lane
      tafa_axis_lane #(
         .AXIS        (g),
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctl_in (lane_ctl),
         .done   (lane_done[g]),
         .req    (req_in),
         .coef   (coef_ff),
         .filt   (filt[g])
      );
   end

   tafa_cordic #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .CORDIC_ITERS    (CORDIC_ITERS),
      .ANG_W           (ANG_W)
   ) u_roll (
      .clock  (clock),
      .reset  (reset),
      .ctl_in (cord_ctl),
      .done   (roll_done),
      .num    (-25'(filt[0])),
      .den    (filt[2]),
      .angle  (roll)
   );

   tafa_cordic #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .CORDIC_ITERS    (CORDIC_ITERS),
      .ANG_W           (ANG_W)
   ) u_pitch (
      .clock  (clock),
      .reset  (reset),
      .ctl_in (cord_ctl),
      .done   (pitch_done),
      .num    (25'(filt[1])),
      .den    (filt[2]),
      .angle  (pitch)
   );

   tafa_merge #(
      .ANG_W (ANG_W)
   ) u_merge (
      .filt_x       (filt[0]),
      .filt_y       (filt[1]),
      .filt_z       (filt[2]),
      .roll         (roll),
      .pitch        (pitch),
      .target_roll  (troll_ff),
      .target_pitch (tpitch_ff),
      .deadband     (db_ff),
      .rsp          (merged)
   );

   always_comb begin
      state_in     = state_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_FILT;
            end
         end
         ST_FILT: begin
            if (lane_done[0]) begin
               state_in = ST_ANGLE;
            end
         end
         ST_ANGLE: begin
            if (roll_done && pitch_done) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               rsp_in       = merged;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      coef_in   = coef_ff;
      troll_in  = troll_ff;
      tpitch_in = tpitch_ff;
      db_in     = db_ff;
      if (csr_we) begin
         case (csr_index)
            tafa_pkg::REG_COEF_B0:      coef_in.b0 = csr_wdata;
            tafa_pkg::REG_COEF_B1:      coef_in.b1 = csr_wdata;
            tafa_pkg::REG_COEF_B2:      coef_in.b2 = csr_wdata;
            tafa_pkg::REG_COEF_A1:      coef_in.a1 = csr_wdata;
            tafa_pkg::REG_COEF_A2:      coef_in.a2 = csr_wdata;
            tafa_pkg::REG_TARGET_ROLL:  troll_in   = csr_wdata;
            tafa_pkg::REG_TARGET_PITCH: tpitch_in  = csr_wdata;
            tafa_pkg::REG_DEADBAND:     db_in      = csr_wdata;
            default: begin
               db_in = db_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         coef_ff      <= '{b0: 16'sd3277, b1: 16'sd3277, b2: 16'sd3277,
                           a1: 16'sd3277, a2: 16'sd3277};
         troll_ff     <= 16'd5760;
         tpitch_ff    <= 16'd5760;
         db_ff        <= 16'd640;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         coef_ff      <= coef_in;
         troll_ff     <= troll_in;
         tpitch_ff    <= tpitch_in;
         db_ff        <= db_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### rtl/core/tafa_checker.sv
// Port-level checks for the tilt angle core, bound to the top level.
`timescale 1ns / 1ps
module tafa_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input tafa_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input tafa_pkg::rsp_type rsp_data,
   input logic              csr_we,
   input logic [2:0]        csr_index,
   input logic [15:0]       csr_wdata
);

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while another is in flight");

   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("response right after request");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

endmodule

bind tilt_angle_from_accel_core tafa_checker u_tafa_checker (.*);

### bench/tilt_angle_from_accel_core_tb.sv
// Self-checking testbench for the accelerometer tilt angle core.
`timescale 1ns / 1ps
module tilt_angle_from_accel_core_tb;

   localparam int FULL_TURN = 360 << 7;

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall, csr_we;
   tafa_pkg::req_type req_data;
   tafa_pkg::rsp_type rsp_data;
   logic [2:0] csr_index;
   logic [15:0] csr_wdata;
   int idle_pct, stall_pct;
   bit timed_out;

   tilt_angle_from_accel_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   class tilt_scoreboard;
      longint b0, b1, b2, a1, a2;
      longint tgt_roll, tgt_pitch, dband;
      longint in_hist[6], out_hist[6];
      tafa_pkg::rsp_type pending_tilt[$];
      int errors;

      function new();
         b0 = 3277; b1 = 3277; b2 = 3277; a1 = 3277; a2 = 3277;
         tgt_roll = 5760; tgt_pitch = 5760; dband = 640;
         foreach (in_hist[i]) begin
            in_hist[i] = 0;
            out_hist[i] = 0;
         end
         errors = 0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [15:0] v);
         case (idx)
            tafa_pkg::REG_COEF_B0: b0 = longint'($signed(v));
            tafa_pkg::REG_COEF_B1: b1 = longint'($signed(v));
            tafa_pkg::REG_COEF_B2: b2 = longint'($signed(v));
            tafa_pkg::REG_COEF_A1: a1 = longint'($signed(v));
            tafa_pkg::REG_COEF_A2: a2 = longint'($signed(v));
            tafa_pkg::REG_TARGET_ROLL: tgt_roll = longint'(v);
            tafa_pkg::REG_TARGET_PITCH: tgt_pitch = longint'(v);
            tafa_pkg::REG_DEADBAND: dband = longint'(v);
            default: ;
         endcase
      endfunction

      function longint round_shift(longint v, int s);
         return (v + (longint'(1) <<< (s - 1))) >>> s;
      endfunction

      function longint clamp24(longint v);
         if (v > 8388607) return 8388607;
         if (v < -8388608) return -8388608;
         return v;
      endfunction

      function longint tilt_angle(longint num, longint den);
         longint x, y, acc, t, dx, dy, a;
         x = den * 256; y = num * 256; acc = 0;
         if (num == 0 && den == 0) return 0;
         if (x < 0) begin
            if (y >= 0) begin
               t = x; x = y; y = -t; acc = longint'(90) <<< 16;
            end else begin
               t = x; x = -y; y = t; acc = -(longint'(90) <<< 16);
            end
         end
         for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
               x += dx; y -= dy; acc += longint'(tafa_pkg::ATAN_TAB[i]);
            end else begin
               x -= dx; y += dy; acc -= longint'(tafa_pkg::ATAN_TAB[i]);
            end
         end
         a = round_shift(acc, 9);
         if (a < 0) a += FULL_TURN;
         if (a >= FULL_TURN) a -= FULL_TURN;
         if (a < 0) a = 0;
         return a;
      endfunction

      function longint tilt_error(longint ang, longint tgt);
         longint d;
         d = (ang >= tgt) ? ang - tgt : tgt - ang;
         return (d < dband) ? 0 : d;
      endfunction

      function void note_request(tafa_pkg::req_type r);
         longint raw[3], filt[3], sum, norm, f, roll, pitch;
         tafa_pkg::rsp_type e;
         raw[0] = longint'(r.raw_x); raw[1] = longint'(r.raw_y);
         raw[2] = longint'(r.raw_z);
         for (int a = 0; a < 3; a++) begin
            sum = 0;
            for (int j = 0; j < 3; j++)
               sum += longint'(tafa_pkg::CAL_MAT[a][j]) * raw[j];
            norm = clamp24(round_shift(sum, 12) + longint'(tafa_pkg::CAL_OFF[a]));
            f = b0 * norm + b1 * in_hist[2*a] + b2 * in_hist[2*a+1]
              + a1 * out_hist[2*a] + a2 * out_hist[2*a+1];
            f = clamp24(round_shift(f, 14));
            in_hist[2*a+1] = in_hist[2*a];
            in_hist[2*a] = norm;
            out_hist[2*a+1] = out_hist[2*a];
            out_hist[2*a] = f;
            filt[a] = f;
         end
         roll = tilt_angle(-filt[0], filt[2]);
         pitch = tilt_angle(filt[1], filt[2]);
         e.filt_x = filt[0][23:0];
         e.filt_y = filt[1][23:0];
         e.filt_z = filt[2][23:0];
         e.roll_deg = roll[15:0];
         e.pitch_deg = pitch[15:0];
         e.roll_error = 16'(tilt_error(roll, tgt_roll));
         e.pitch_error = 16'(tilt_error(pitch, tgt_pitch));
         pending_tilt.push_back(e);
      endfunction

      task report(string what, longint got, longint want);
         $display("mismatch %s: got %0d expected %0d", what, got, want);
         errors++;
      endtask

      task check_response(tafa_pkg::rsp_type r);
         tafa_pkg::rsp_type e;
         if (pending_tilt.size() == 0) begin
            report("unexpected response", 1, 0);
            return;
         end
         e = pending_tilt.pop_front();
         if (r.filt_x !== e.filt_x) report("filt_x", r.filt_x, e.filt_x);
         if (r.filt_y !== e.filt_y) report("filt_y", r.filt_y, e.filt_y);
         if (r.filt_z !== e.filt_z) report("filt_z", r.filt_z, e.filt_z);
         if (r.roll_deg !== e.roll_deg) report("roll_deg", r.roll_deg, e.roll_deg);
         if (r.pitch_deg !== e.pitch_deg) report("pitch_deg", r.pitch_deg, e.pitch_deg);
         if (r.roll_error !== e.roll_error)
            report("roll_error", r.roll_error, e.roll_error);
         if (r.pitch_error !== e.pitch_error)
            report("pitch_error", r.pitch_error, e.pitch_error);
      endtask
   endclass

   tilt_scoreboard sb = new();

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_data);
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_data);
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
      while ($urandom_range(99) < idle_pct) @(negedge clock);
      req_valid = 1;
      req_data.raw_x = x; req_data.raw_y = y; req_data.raw_z = z;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      req_valid = 0;
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] v);
      csr_we = 1; csr_index = idx; csr_wdata = v;
      @(posedge clock);
      sb.set_reg(idx, v);
      @(negedge clock);
      csr_we = 0;
   endtask

   task automatic drain();
      while (sb.pending_tilt.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic load_settings(logic [15:0] cb0, logic [15:0] cb1, logic [15:0] cb2,
                                logic [15:0] ca1, logic [15:0] ca2, logic [15:0] tr,
                                logic [15:0] tp, logic [15:0] db);
      drain();
      write_reg(tafa_pkg::REG_COEF_B0, cb0);
      write_reg(tafa_pkg::REG_COEF_B1, cb1);
      write_reg(tafa_pkg::REG_COEF_B2, cb2);
      write_reg(tafa_pkg::REG_COEF_A1, ca1);
      write_reg(tafa_pkg::REG_COEF_A2, ca2);
      write_reg(tafa_pkg::REG_TARGET_ROLL, tr);
      write_reg(tafa_pkg::REG_TARGET_PITCH, tp);
      write_reg(tafa_pkg::REG_DEADBAND, db);
   endtask

   task automatic random_samples(int n);
      logic [15:0] v[3];
      for (int k = 0; k < n; k++) begin
         for (int j = 0; j < 3; j++) begin
            case ($urandom_range(3))
               0: v[j] = 16'($urandom());
               1: v[j] = 16'($signed($urandom_range(2000)) - 1000);
               2: v[j] = $urandom_range(1) ? 16'(16'h7fff - $urandom_range(3))
                                            : 16'(16'h8000 + $urandom_range(3));
               default: v[j] = 16'($signed($urandom_range(20000)) - 10000);
            endcase
         end
         send_sample(v[0], v[1], v[2]);
      end
   endtask

   initial begin
      reset = 1; req_valid = 0; req_data = '0;
      csr_we = 0; csr_index = '0; csr_wdata = '0;
      idle_pct = 0; stall_pct = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: corners under reset settings
      send_sample(16'h0000, 16'h0000, 16'h0000);
      for (int c = 0; c < 8; c++)
         send_sample(c[0] ? 16'h7fff : 16'h8000, c[1] ? 16'h7fff : 16'h8000,
                     c[2] ? 16'h7fff : 16'h8000);
      send_sample(16'h0000, 16'h0000, 16'h4000);
      send_sample(16'h0000, 16'h0000, 16'hc000);
      send_sample(16'h4000, 16'h0000, 16'h0000);
      send_sample(16'h0000, 16'hc000, 16'h0000);
      send_sample(16'h0001, 16'hffff, 16'h0001);
      // zero vector: all taps cleared
      load_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                    16'd0, 16'd46079, 16'd0);
      send_sample(16'h1234, 16'h8000, 16'h7fff);
      send_sample(16'h0000, 16'h0000, 16'h0000);
      // pass-through filter, negative z and angle wrap regions
      load_settings(16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                    16'd46079, 16'd0, 16'd46079);
      send_sample(16'hffff, 16'h0000, 16'hc000);
      send_sample(16'h0000, 16'hfff0, 16'h4000);
      send_sample(16'h0000, 16'h0010, 16'h4000);
      send_sample(16'hfffe, 16'hffec, 16'h8000);
      send_sample(16'h0000, 16'h0000, 16'h8000);
      random_samples(250);

      load_settings(16'h3277, 16'hf000, 16'h0800, 16'h1000, 16'hfc00,
                    16'($urandom_range(46079)), 16'($urandom_range(46079)),
                    16'($urandom_range(3000)));
      idle_pct = 72; stall_pct = 0;
      random_samples(260);

      load_settings(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                    16'd46079, 16'd46079, 16'd46079);
      idle_pct = 0; stall_pct = 72;
      random_samples(260);

      load_settings(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                    16'd0, 16'd0, 16'd1000);
      idle_pct = 21; stall_pct = 21;
      random_samples(260);

      load_settings(16'($urandom()), 16'($urandom()), 16'($urandom()),
                    16'($urandom()), 16'($urandom()),
                    16'($urandom_range(46079)), 16'($urandom_range(46079)),
                    16'($urandom_range(46079)));
      idle_pct = 0; stall_pct = 0;
      random_samples(250);

      drain();
      if (sb.errors == 0 && !timed_out) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      timed_out = 0;
      #10ms;
      timed_out = 1;
      $display("status: fail");
      $finish;
   end

endmodule
